// ----- hdl/est_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg: shared types and constants of the endpoint statistics table
// Request and result records, the stored row layout and the front/back status.
// ----------------------------------------------------------------------------
package est_pkg;

	localparam int MaxEntries      = 64;
	localparam int TableEntriesDef = 64;
	localparam int SlotW           = 6;
	localparam int CntW            = 7;
	localparam int QueueDepth      = 2;

	localparam logic [30:0] DelayMax = 31'h7FFF_FFFF;

	// request function codes
	localparam logic [1:0] FUNC_DELAY = 2'd0;
	localparam logic [1:0] FUNC_OUTCM = 2'd1;
	localparam logic [1:0] FUNC_BYTES = 2'd2;
	localparam logic [1:0] FUNC_DUMP  = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_UPDATED  = 3'd0;
	localparam logic [2:0] KIND_INSERTED = 3'd1;
	localparam logic [2:0] KIND_DROPPED  = 3'd2;
	localparam logic [2:0] KIND_RECORD   = 3'd3;
	localparam logic [2:0] KIND_EMPTY    = 3'd4;

	// classified request, front to back
	typedef struct packed {
		logic [1:0]       func;
		logic [2:0]       kind;
		logic [SlotW-1:0] slot;
		logic [47:0]      key;
		logic [30:0]      delay;
		logic             success;
		logic [63:0]      send;
		logic [63:0]      recv;
		logic [31:0]      now;
	} cmd_t;

	// one stored table row
	typedef struct packed {
		logic [47:0] key;
		logic [30:0] mn;
		logic [30:0] mx;
		logic [63:0] sum;
		logic [31:0] ok;
		logic [31:0] fail;
		logic [31:0] best;
		logic [31:0] cur;
		logic [63:0] sent;
		logic [63:0] recvd;
	} row_t;

	// one result record
	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] key;
		logic [30:0] mn;
		logic [30:0] mx;
		logic [30:0] avg;
		logic [31:0] ok;
		logic [31:0] fail;
		logic [31:0] run;
		logic [63:0] sent;
		logic [63:0] recvd;
		logic [31:0] gap;
		logic        last;
	} res_t;

	// occupancy seen by the back part during a dump
	typedef struct packed {
		logic [MaxEntries-1:0] valid;
		logic [CntW-1:0]       count;
	} occ_t;

endpackage

// ----- hdl/est_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_if: request and result channels
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface est_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] ip_addr;
	logic [15:0] port_num;
	logic [30:0] delay_value;
	logic        success;
	logic [63:0] send_bytes;
	logic [63:0] recv_bytes;
	logic [31:0] now_seconds;

	modport source(output valid, func, ip_addr, port_num, delay_value, success,
		send_bytes, recv_bytes, now_seconds, input ready);
	modport sink(input valid, func, ip_addr, port_num, delay_value, success,
		send_bytes, recv_bytes, now_seconds, output ready);
endinterface

interface est_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [47:0] entry_id;
	logic [30:0] delay_lo;
	logic [30:0] delay_hi;
	logic [30:0] delay_mean;
	logic [31:0] ok_count;
	logic [31:0] fail_count;
	logic [31:0] longest_fail_run;
	logic [63:0] send_total;
	logic [63:0] recv_total;
	logic [31:0] window_gap;
	logic        last;

	modport source(output valid, result_kind, entry_id, delay_lo, delay_hi,
		delay_mean, ok_count, fail_count, longest_fail_run, send_total, recv_total,
		window_gap, last, input ready);
	modport sink(input valid, result_kind, entry_id, delay_lo, delay_hi,
		delay_mean, ok_count, fail_count, longest_fail_run, send_total, recv_total,
		window_gap, last, output ready);
endinterface

// ----- hdl/est_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_queue: command queue between front and back
// Small FIFO of classified requests so each side can stall on its own.
// ----------------------------------------------------------------------------
module est_queue
	import est_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int PtrW = $clog2(QueueDepth);

	cmd_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [PtrW:0]   cnt_q;

	assign full  = (cnt_q == (PtrW+1)'(QueueDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/est_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_front: request intake and key match
// Matches the key against all entries at once, allocates a free slot for a
// new key and queues the classified request. Holds off after a dump request
// until the back part reports the dump done.
// ----------------------------------------------------------------------------
module est_front
	import est_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	est_req_if.sink req_ch,
	input  logic q_full,
	output logic push,
	output cmd_t push_data,
	output occ_t occ,
	input  logic dump_done
);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [47:0]              key_q [TABLE_ENTRIES];
	logic [CntW-1:0]          cnt_q;
	logic                     dump_busy_q;

	logic [47:0]      key;
	logic             hit;
	logic             has_free;
	logic [SlotW-1:0] hit_slot;
	logic [SlotW-1:0] free_slot;
	logic             is_dump;
	logic             insert;

	assign key     = {req_ch.ip_addr, req_ch.port_num};
	assign is_dump = (req_ch.func == FUNC_DUMP);

	// parallel key match and first free slot
	always_comb begin
		hit       = 1'b0;
		has_free  = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key) begin
				hit      = 1'b1;
				hit_slot = SlotW'(i);
			end
			if (!valid_q[i]) begin
				has_free  = 1'b1;
				free_slot = SlotW'(i);
			end
		end
	end

	assign req_ch.ready = !dump_busy_q && !q_full;
	assign push         = req_ch.valid && req_ch.ready;
	assign insert       = push && !is_dump && !hit && has_free;

	// classified request
	always_comb begin
		push_data.func    = req_ch.func;
		push_data.slot    = hit ? hit_slot : free_slot;
		push_data.key     = key;
		push_data.delay   = req_ch.delay_value;
		push_data.success = req_ch.success;
		push_data.send    = req_ch.send_bytes;
		push_data.recv    = req_ch.recv_bytes;
		push_data.now     = req_ch.now_seconds;
		if (hit) begin
			push_data.kind = KIND_UPDATED;
		end else if (has_free) begin
			push_data.kind = KIND_INSERTED;
		end else begin
			push_data.kind = KIND_DROPPED;
		end
	end

	always_comb begin
		occ.valid                     = '0;
		occ.valid[TABLE_ENTRIES-1:0]  = valid_q;
		occ.count                     = cnt_q;
	end

	// key store
	always_ff @(posedge clk) begin
		if (insert) begin
			key_q[free_slot[$clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2)-1:0]] <= key;
		end
	end

	// occupancy and dump hold-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			dump_busy_q <= 1'b0;
		end else begin
			if (dump_done) begin
				valid_q     <= '0;
				cnt_q       <= '0;
				dump_busy_q <= 1'b0;
			end else begin
				if (insert) begin
					valid_q[free_slot[$clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2)-1:0]]
						<= 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end
				if (push && is_dump) begin
					dump_busy_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/est_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_back: statistics store and dump engine
// Read-modify-write of one row per update request. A dump walks the table
// once per record to find the next larger key, divides the delay sum by a
// nonzero success count one quotient bit a cycle, and emits the record.
// ----------------------------------------------------------------------------
module est_back
	import est_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_head,
	output logic pop,
	input  occ_t occ,
	output logic dump_done,
	est_res_if.source res_ch
);

	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_UPD      = 3'd1;
	localparam logic [2:0] S_EMPTY    = 3'd2;
	localparam logic [2:0] S_SCAN_RD  = 3'd3;
	localparam logic [2:0] S_SCAN_CMP = 3'd4;
	localparam logic [2:0] S_DIV_INIT = 3'd5;
	localparam logic [2:0] S_DIV      = 3'd6;
	localparam logic [2:0] S_DUMP_OUT = 3'd7;

	row_t mem [TABLE_ENTRIES];
	row_t rd_q;

	logic [2:0]      state_q;
	cmd_t            cmd_q;
	logic [31:0]     window_q;
	logic [31:0]     gap_q;
	logic [IdxW-1:0] scan_q;
	logic            first_q;
	logic            found_q;
	logic [47:0]     thresh_q;
	row_t            rec_q;
	logic [CntW-1:0] emit_q;
	logic [31:0]     rem_q;
	logic [63:0]     quo_q;
	logic [5:0]      div_cnt_q;
	logic            avg_zero_q;

	logic            out_v_q;
	res_t            out_q;
	logic            out_free;
	logic            load_out;
	res_t            out_next;

	logic [IdxW-1:0] rd_addr;
	logic            wr_en;
	row_t            upd_row;
	row_t            base;
	res_t            rec_res;
	logic            cand;
	logic            rec_last;
	logic [32:0]     rem_sh;
	logic [31:0]     rem_sub;
	logic            q_bit;

	assign out_free = !out_v_q || res_ch.ready;
	assign pop      = (state_q == S_IDLE) && !q_empty;

	// read address: head on pop, held command while updating, scan index in a dump
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = q_head.slot[IdxW-1:0];
		end else if (state_q == S_UPD) begin
			rd_addr = cmd_q.slot[IdxW-1:0];
		end else begin
			rd_addr = scan_q;
		end
	end

	// row update
	always_comb begin
		if (cmd_q.kind == KIND_INSERTED) begin
			base       = '0;
			base.key   = cmd_q.key;
			base.mn    = DelayMax;
		end else begin
			base = rd_q;
		end
		upd_row = base;
		case (cmd_q.func)
			FUNC_DELAY: begin
				if (base.mn > cmd_q.delay) upd_row.mn = cmd_q.delay;
				if (base.mx < cmd_q.delay) upd_row.mx = cmd_q.delay;
				upd_row.sum = base.sum + {33'd0, cmd_q.delay};
			end
			FUNC_OUTCM: begin
				if (!cmd_q.success) begin
					upd_row.fail = base.fail + 32'd1;
					upd_row.cur  = base.cur + 32'd1;
				end else begin
					upd_row.ok   = base.ok + 32'd1;
					upd_row.best = (base.cur > base.best) ? base.cur : base.best;
					upd_row.cur  = '0;
				end
			end
			default: begin
				upd_row.sent  = base.sent + cmd_q.send;
				upd_row.recvd = base.recvd + cmd_q.recv;
			end
		endcase
	end

	assign wr_en = (state_q == S_UPD) && out_free && (cmd_q.kind != KIND_DROPPED);

	// row store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd_q.slot[IdxW-1:0]] <= upd_row;
		end
		rd_q <= mem[rd_addr];
	end

	// next-key candidate during a scan
	assign cand = occ.valid[scan_q] && (first_q || rd_q.key > thresh_q) &&
		(!found_q || rd_q.key < rec_q.key);

	// one restoring division step; the remainder stays below the divisor
	assign rem_sh  = {rem_q, quo_q[63]};
	assign rem_sub = rem_sh[31:0] - rec_q.ok;
	assign q_bit   = (rem_sh >= {1'b0, rec_q.ok});

	assign rec_last = ((emit_q + 1'b1) == occ.count);

	// dump record
	always_comb begin
		rec_res.kind = KIND_RECORD;
		rec_res.key  = rec_q.key;
		rec_res.mn   = rec_q.mn;
		rec_res.mx   = rec_q.mx;
		if (avg_zero_q) begin
			rec_res.avg = '0;
		end else if (quo_q[63:31] != '0) begin
			rec_res.avg = DelayMax;
		end else begin
			rec_res.avg = quo_q[30:0];
		end
		rec_res.ok    = rec_q.ok;
		rec_res.fail  = rec_q.fail;
		rec_res.run   = (rec_q.cur > rec_q.best) ? rec_q.cur : rec_q.best;
		rec_res.sent  = rec_q.sent;
		rec_res.recvd = rec_q.recvd;
		rec_res.gap   = gap_q;
		rec_res.last  = rec_last;
	end

	assign dump_done = ((state_q == S_EMPTY) || (state_q == S_DUMP_OUT && rec_last))
		&& out_free;

	// next result: update answer, empty dump or dump record
	assign load_out = out_free &&
		((state_q == S_UPD) || (state_q == S_EMPTY) || (state_q == S_DUMP_OUT));

	always_comb begin
		out_next = '0;
		if (state_q == S_DUMP_OUT) begin
			out_next = rec_res;
		end else if (state_q == S_EMPTY) begin
			out_next.kind = KIND_EMPTY;
			out_next.gap  = gap_q;
			out_next.last = 1'b1;
		end else begin
			out_next.kind = cmd_q.kind;
			out_next.key  = cmd_q.key;
			out_next.last = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_next;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			window_q  <= '0;
			scan_q    <= '0;
			first_q   <= 1'b0;
			found_q   <= 1'b0;
			emit_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_head;
						gap_q <= q_head.now - window_q;
						if (q_head.func == FUNC_DUMP) begin
							first_q <= 1'b1;
							found_q <= 1'b0;
							emit_q  <= '0;
							scan_q  <= '0;
							state_q <= (occ.count == '0) ? S_EMPTY : S_SCAN_RD;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						window_q <= cmd_q.now;
						state_q  <= S_IDLE;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (cand) begin
						found_q <= 1'b1;
						rec_q   <= rd_q;
					end
					if (scan_q == IdxW'(TABLE_ENTRIES - 1)) begin
						state_q <= S_DIV_INIT;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_DIV_INIT: begin
					rem_q      <= '0;
					quo_q      <= rec_q.sum;
					div_cnt_q  <= '0;
					avg_zero_q <= (rec_q.ok == '0);
					state_q    <= (rec_q.ok == '0) ? S_DUMP_OUT : S_DIV;
				end
				S_DIV: begin
					rem_q     <= q_bit ? rem_sub : rem_sh[31:0];
					quo_q     <= {quo_q[62:0], q_bit};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 6'd63) begin
						state_q <= S_DUMP_OUT;
					end
				end
				S_DUMP_OUT: begin
					if (out_free) begin
						thresh_q <= rec_q.key;
						first_q  <= 1'b0;
						found_q  <= 1'b0;
						emit_q   <= emit_q + 1'b1;
						scan_q   <= '0;
						if (rec_last) begin
							window_q <= cmd_q.now;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result channel
	assign res_ch.valid            = out_v_q;
	assign res_ch.result_kind      = out_q.kind;
	assign res_ch.entry_id         = out_q.key;
	assign res_ch.delay_lo         = out_q.mn;
	assign res_ch.delay_hi         = out_q.mx;
	assign res_ch.delay_mean       = out_q.avg;
	assign res_ch.ok_count         = out_q.ok;
	assign res_ch.fail_count       = out_q.fail;
	assign res_ch.longest_fail_run = out_q.run;
	assign res_ch.send_total       = out_q.sent;
	assign res_ch.recv_total       = out_q.recvd;
	assign res_ch.window_gap       = out_q.gap;
	assign res_ch.last             = out_q.last;

endmodule

// ----- hdl/endpoint_stats_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// endpoint_stats_table: per-endpoint statistics table
// Bounded table of delay, outcome and byte statistics keyed by {ip, port}.
//
//   channel  dir  content
//   req_ch   in   func, key, delay, outcome, byte counts, time
//   res_ch   out  one result per update, one record per entry on dump (one empty result if none)
//
// An update pops with a row read, then writes the row and loads the result;
// the result is then offered from the output register.
// A dump record takes a read and compare per table entry, a divider setup, the
// division (none when the success count is 0) and an output step.
// Requests behind a dump wait for its last record; reset clears occupancy and control.
// A stalled result side holds the back part; the queue lets the front run on.
// ----------------------------------------------------------------------------
module endpoint_stats_table
	import est_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	est_req_if.sink   req_ch,
	est_res_if.source res_ch
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_data;
	cmd_t q_head;
	occ_t occ;
	logic dump_done;

	est_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.occ       (occ),
		.dump_done (dump_done)
	);

	est_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	est_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.occ       (occ),
		.dump_done (dump_done),
		.res_ch    (res_ch)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: endpoint statistics table
// Drives delay, outcome, byte and dump requests through the request channel
// and checks every result record against a behavioral copy of the table:
// insert, update and drop per key, sorted dump records with average, longest
// failure run and window gap, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
	import est_pkg::*;
();

	localparam int SLOTS      = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_WAIT = 300;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] ip;
		logic [15:0] port;
		logic [30:0] delay;
		logic        success;
		logic [63:0] send;
		logic [63:0] recv;
		logic [31:0] now;
		bit          has_kind;
		logic [2:0]  kind;
		bit          has_gap;
		logic [31:0] gap;
	} stim_t;

	logic clk;
	logic arst_n;
	est_req_if req_ch();
	est_res_if res_ch();

	endpoint_stats_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch),
		.res_ch(res_ch)
	);

	// statistics table copy
	bit          tv_valid[SLOTS];
	logic [47:0] tv_key[SLOTS];
	logic [30:0] tv_min[SLOTS];
	logic [30:0] tv_max[SLOTS];
	logic [63:0] tv_sum[SLOTS];
	logic [31:0] tv_ok[SLOTS];
	logic [31:0] tv_fail[SLOTS];
	logic [31:0] tv_best[SLOTS];
	logic [31:0] tv_cur[SLOTS];
	logic [63:0] tv_sent[SLOTS];
	logic [63:0] tv_recvd[SLOTS];
	logic [31:0] window_start;

	res_t pending_results[$];
	int   mismatches;
	int   send_idle;
	int   recv_idle;
	int   hold_cycles;
	int   idle_cycles;

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int find_key(logic [47:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (tv_valid[i] && tv_key[i] == key)
				return i;
		return -1;
	endfunction

	// update the table copy for one accepted request and queue its results
	function automatic void table_apply(stim_t s);
		logic [47:0] key;
		res_t r;
		int slot;
		int order[SLOTS];
		int n;
		int j;
		logic [63:0] avg;
		key = {s.ip, s.port};
		r = '0;
		if (s.func == FUNC_DUMP) begin
			n = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!tv_valid[i])
					continue;
				j = n;
				while (j > 0 && tv_key[order[j-1]] > tv_key[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
				n++;
			end
			if (n == 0) begin
				r.kind = KIND_EMPTY;
				r.gap = s.now - window_start;
				r.last = 1'b1;
				if (s.has_kind)
					r.kind = s.kind;
				if (s.has_gap)
					r.gap = s.gap;
				pending_results.push_back(r);
			end
			for (int i = 0; i < n; i++) begin
				slot = order[i];
				avg = '0;
				if (tv_ok[slot] != 0) begin
					avg = tv_sum[slot] / {32'd0, tv_ok[slot]};
					if (avg > {33'd0, DelayMax})
						avg = {33'd0, DelayMax};
				end
				r = '0;
				r.kind = KIND_RECORD;
				r.key = tv_key[slot];
				r.mn = tv_min[slot];
				r.mx = tv_max[slot];
				r.avg = avg[30:0];
				r.ok = tv_ok[slot];
				r.fail = tv_fail[slot];
				r.run = (tv_cur[slot] > tv_best[slot]) ? tv_cur[slot] : tv_best[slot];
				r.sent = tv_sent[slot];
				r.recvd = tv_recvd[slot];
				r.gap = s.now - window_start;
				r.last = (i == n - 1);
				pending_results.push_back(r);
			end
			for (int i = 0; i < SLOTS; i++)
				tv_valid[i] = 1'b0;
			window_start = s.now;
			return;
		end
		r.key = key;
		r.last = 1'b1;
		r.kind = KIND_UPDATED;
		slot = find_key(key);
		if (slot < 0) begin
			for (int i = 0; i < SLOTS; i++)
				if (!tv_valid[i]) begin
					slot = i;
					break;
				end
			if (slot < 0) begin
				r.kind = KIND_DROPPED;
			end else begin
				r.kind = KIND_INSERTED;
				tv_valid[slot] = 1'b1;
				tv_key[slot] = key;
				tv_min[slot] = DelayMax;
				tv_max[slot] = '0;
				tv_sum[slot] = '0;
				tv_ok[slot] = '0;
				tv_fail[slot] = '0;
				tv_best[slot] = '0;
				tv_cur[slot] = '0;
				tv_sent[slot] = '0;
				tv_recvd[slot] = '0;
			end
		end
		if (slot >= 0) begin
			case (s.func)
				FUNC_DELAY: begin
					if (tv_min[slot] > s.delay)
						tv_min[slot] = s.delay;
					if (tv_max[slot] < s.delay)
						tv_max[slot] = s.delay;
					tv_sum[slot] += {33'd0, s.delay};
				end
				FUNC_OUTCM: begin
					if (!s.success) begin
						tv_fail[slot]++;
						tv_cur[slot]++;
					end else begin
						tv_ok[slot]++;
						if (tv_cur[slot] > tv_best[slot])
							tv_best[slot] = tv_cur[slot];
						tv_cur[slot] = '0;
					end
				end
				default: begin
					tv_sent[slot] += s.send;
					tv_recvd[slot] += s.recv;
				end
			endcase
		end
		if (s.has_kind)
			r.kind = s.kind;
		pending_results.push_back(r);
	endfunction

	function automatic stim_t mk(logic [1:0] func, logic [31:0] ip, logic [15:0] port,
		logic [30:0] delay, logic success, logic [63:0] send, logic [63:0] recv,
		logic [31:0] now);
		stim_t s;
		s.func = func;
		s.ip = ip;
		s.port = port;
		s.delay = delay;
		s.success = success;
		s.send = send;
		s.recv = recv;
		s.now = now;
		s.has_kind = 0;
		s.kind = '0;
		s.has_gap = 0;
		s.gap = '0;
		return s;
	endfunction

	function automatic stim_t with_kind(stim_t s, logic [2:0] kind);
		s.has_kind = 1;
		s.kind = kind;
		return s;
	endfunction

	function automatic stim_t rand_request(logic [1:0] func, logic [47:0] key);
		return mk(func, key[47:16], key[15:0], 31'($urandom()), 1'($urandom_range(1)),
			{$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
	endfunction

	// offer one request; entered and left at a falling edge
	task automatic send_request(stim_t s);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.func = s.func;
		req_ch.ip_addr = s.ip;
		req_ch.port_num = s.port;
		req_ch.delay_value = s.delay;
		req_ch.success = s.success;
		req_ch.send_bytes = s.send;
		req_ch.recv_bytes = s.recv;
		req_ch.now_seconds = s.now;
		req_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		table_apply(s);
		@(negedge clk);
	endtask

	// result side ready, with random idling and long holds
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_ch.ready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_ch.ready = ($urandom_range(99) >= recv_idle);
		end
	end

	// result checking
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.result_kind, res_ch.entry_id, res_ch.delay_lo,
				res_ch.delay_hi, res_ch.delay_mean, res_ch.ok_count,
				res_ch.fail_count, res_ch.longest_fail_run, res_ch.send_total,
				res_ch.recv_total, res_ch.window_gap, res_ch.last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch:\n  exp %p\n  got %p", want, got);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL endpoint_stats_table");
			$finish;
		end
	end

	// random traffic on a small key pool so most requests hit existing rows
	task automatic random_traffic(int count);
		logic [47:0] pool[12];
		int pick;
		logic [1:0] func;
		for (int i = 0; i < 12; i++)
			pool[i] = 48'({$urandom(), $urandom()});
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(11);
			if ($urandom_range(7) == 0)
				pool[pick] = 48'({$urandom(), $urandom()});
			if ($urandom_range(24) == 0)
				func = FUNC_DUMP;
			else
				func = 2'($urandom_range(2));
			send_request(rand_request(func, pool[pick]));
		end
	endtask

	// fill every row, then offer a new key and an update on a full table
	task automatic fill_table();
		logic [47:0] key;
		logic [47:0] first_key;
		send_request(rand_request(FUNC_DUMP, '0));
		for (int i = 0; i < SLOTS; i++) begin
			do
				key = 48'({$urandom(), $urandom()});
			while (find_key(key) >= 0);
			if (i == 0)
				first_key = key;
			send_request(rand_request(2'($urandom_range(2)), key));
		end
		do
			key = 48'({$urandom(), $urandom()});
		while (find_key(key) >= 0);
		send_request(rand_request(FUNC_DELAY, key));
		send_request(rand_request(FUNC_OUTCM, first_key));
		send_request(rand_request(FUNC_DUMP, '0));
	endtask

	initial begin
		stim_t plan[$];
		int waited;
		stim_t e;
		mismatches = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		idle_cycles = 0;
		window_start = '0;
		for (int i = 0; i < SLOTS; i++)
			tv_valid[i] = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_DELAY;
		req_ch.ip_addr = '0;
		req_ch.port_num = '0;
		req_ch.delay_value = '0;
		req_ch.success = 1'b0;
		req_ch.send_bytes = '0;
		req_ch.recv_bytes = '0;
		req_ch.now_seconds = '0;
		res_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed requests
		e = mk(FUNC_DUMP, 32'h0, 16'h0, '0, 1'b0, '0, '0, 32'h0000_1234);
		e = with_kind(e, KIND_EMPTY);
		e.has_gap = 1;
		e.gap = 32'h0000_1234;
		plan.push_back(e);
		plan.push_back(with_kind(mk(FUNC_DELAY, 32'h0, 16'h0, 31'd0, 1'b0, '0, '0, '0),
			KIND_INSERTED));
		plan.push_back(with_kind(mk(FUNC_DELAY, '1, '1, DelayMax, 1'b1, '0, '0, '0),
			KIND_INSERTED));
		plan.push_back(with_kind(mk(FUNC_DELAY, '1, '1, 31'd5, 1'b0, '0, '0, '0),
			KIND_UPDATED));
		plan.push_back(mk(FUNC_OUTCM, 32'h0, 16'h0, '0, 1'b0, '0, '0, '0));
		plan.push_back(mk(FUNC_OUTCM, 32'h0, 16'h0, '0, 1'b0, '0, '0, '0));
		plan.push_back(mk(FUNC_OUTCM, 32'h0, 16'h0, '0, 1'b1, '0, '0, '0));
		plan.push_back(mk(FUNC_OUTCM, 32'h0, 16'h0, '0, 1'b0, '0, '0, '0));
		plan.push_back(mk(FUNC_BYTES, 32'h0, 16'h0, '0, 1'b0, '1, '1, '0));
		plan.push_back(mk(FUNC_BYTES, 32'h0, 16'h0, '0, 1'b0, 64'd1, 64'd2, '0));
		plan.push_back(mk(FUNC_OUTCM, '1, '1, '0, 1'b1, '0, '0, '0));
		plan.push_back(with_kind(mk(FUNC_BYTES, 32'h8000_0000, 16'h8000, '0, 1'b0,
			64'd0, 64'd0, '0), KIND_INSERTED));
		// large delay sum over one success: the average saturates
		for (int i = 0; i < 3; i++)
			plan.push_back(mk(FUNC_DELAY, 32'h1, 16'h1, DelayMax, 1'b0, '0, '0, '0));
		plan.push_back(mk(FUNC_OUTCM, 32'h1, 16'h1, '0, 1'b1, '0, '0, '0));
		plan.push_back(mk(FUNC_DUMP, '0, '0, '0, 1'b0, '0, '0, 32'hFFFF_FFFF));
		e = mk(FUNC_DUMP, '0, '0, '0, 1'b0, '0, '0, 32'd5);
		e = with_kind(e, KIND_EMPTY);
		e.has_gap = 1;
		e.gap = 32'd6;
		plan.push_back(e);
		@(negedge clk);
		foreach (plan[i])
			send_request(plan[i]);

		// random traffic under three idling patterns
		send_idle = 30;
		recv_idle = 63;
		random_traffic(140);
		send_idle = 63;
		recv_idle = 30;
		hold_cycles = 600;
		random_traffic(140);
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 400;
		random_traffic(60);
		fill_table();
		random_traffic(60);
		req_ch.valid = 1'b0;

		// drain
		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS endpoint_stats_table");
		else
			$display("FAIL endpoint_stats_table");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/est_pkg.sv
hdl/est_if.sv
hdl/est_queue.sv
hdl/est_front.sv
hdl/est_back.sv
hdl/endpoint_stats_table.sv
tb/testbench.sv
